[src/lbp3_pkg.sv]
// Constants, types and helpers for the 3x3 local binary pattern operator.
// Depends on nothing; lbp_3x3_operator imports it.
package lbp3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int COL_W      = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = 16;
  localparam int PIX_W      = 8;
  localparam int WIDTH_FW   = 11;
  localparam int CFG_DW     = 16;
  localparam int CFG_IW     = 2;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [COL_W-1:0] WIDTH_RST  = COL_W'(128);
  localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(128);

  typedef enum logic [CFG_IW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef logic [PIX_W-1:0] pix_t;
  // rows 0 (top) to 2 (bottom) of one window column
  typedef pix_t [2:0] col_t;
  // columns 0 (left) to 2 (right)
  typedef col_t [2:0] win_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_t;

  typedef struct packed {
    logic shift;
    logic dbl;
    logic emit_c0;
    logic emit_main;
    logic top0;
    logic left0;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } ctl_t;

  typedef struct packed {
    pix_t code;
    logic last;
  } res_t;

  function automatic logic [COL_W-1:0] clamp_width(input logic [WIDTH_FW-1:0] v);
    logic [COL_W-1:0] w;
    if (v == '0) begin
      w = COL_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      w = COL_W'(MAX_WIDTH);
    end else begin
      w = COL_W'(v);
    end
    return w;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] v);
    return (v == '0) ? ROW_W'(1) : v;
  endfunction

  function automatic pix_t lbp_calc(input win_t g, input logic top, input logic bot,
                                    input logic left, input logic right);
    pix_t c;
    pix_t v;
    c    = g[1][1];
    v    = '0;
    v[7] = top & left  & (g[0][0] >= c);
    v[6] = top         & (g[1][0] >= c);
    v[5] = top & right & (g[2][0] >= c);
    v[4] = right       & (g[2][1] >= c);
    v[3] = bot & right & (g[2][2] >= c);
    v[2] = bot         & (g[1][2] >= c);
    v[1] = bot & left  & (g[0][2] >= c);
    v[0] = left        & (g[0][1] >= c);
    return v;
  endfunction

endpackage

[src/lbp_3x3_operator.sv]
// 3x3 local binary pattern operator: line memory, window, code logic and output queue.
// Depends on lbp3_pkg.
//
// Takes one grey pixel per clock in raster order unless stalled and returns one 8-bit
// code per pixel, one row and one pixel behind the input. After a frame's last pixel,
// send flush requests to drain the remaining codes: width + 1 of them for a height of
// two or more, width for a height of one; frame_last marks the final code. The line
// memory is read at acceptance and written back in the next cycle, with write-to-read
// forwarding, so a request can be accepted every cycle unless stalled. A four-entry
// output queue keeps the input running while the result side stalls. Configuration
// writes restart the frame and must only arrive when the block is idle.
module lbp_3x3_operator
  import lbp3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [PIX_W-1:0]  in_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  out_lbp_code,
  output logic              out_frame_last,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [COL_W-1:0]   width_r;
  logic [ROW_W-1:0]   height_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic               in_acc;
  logic               frame_done, pix_go, flush_go, col_zero;
  logic [LINE_AW-1:0] addr_a, addr_b;
  ctl_t               ctl_nxt;

  line_t              line_mem [MAX_WIDTH];
  line_t              rd_a_r, rd_b_r;
  logic               fwd_a_r, fwd_b_r;
  line_t              fwd_word_r;

  logic               s1_valid_r;
  ctl_t               s1_ctl_r;
  logic               s1_wr_r;
  pix_t               s1_pix_r;
  logic [LINE_AW-1:0] s1_addr_r;

  win_t               win_r, win_sh, win_c0;
  line_t              line_a, line_b, wr_word;
  col_t               col_a, col_b;
  logic               s1_emit;
  res_t               res;

  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               pop;

  assign in_acc = in_valid && !in_stall;

  // request decode and frame counters
  always_comb begin
    frame_done = (row_r == height_r);
    pix_go     = (in_kind == KIND_PIXEL) && !frame_done;
    flush_go   = (in_kind == KIND_FLUSH) && frame_done;
    col_zero   = (col_r == '0);
    addr_a     = col_r[LINE_AW-1:0];
    addr_b     = addr_a + LINE_AW'(1);

    ctl_nxt       = '0;
    ctl_nxt.shift = pix_go || flush_go;
    ctl_nxt.top0  = (row_r >= ROW_W'(3));
    ctl_nxt.left0 = (width_r >= COL_W'(2));
    ctl_nxt.top   = (row_r >= ROW_W'(2));
    ctl_nxt.bot   = pix_go;
    ctl_nxt.left  = (col_r >= COL_W'(2));
    ctl_nxt.right = (col_r < width_r);

    col_nxt = col_r;
    row_nxt = row_r;
    if (pix_go) begin
      ctl_nxt.emit_c0   = col_zero && (row_r >= ROW_W'(2));
      ctl_nxt.emit_main = !col_zero && (row_r != '0);
      if (col_r + COL_W'(1) == width_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else if (flush_go) begin
      if (col_zero && (height_r >= ROW_W'(2))) begin
        ctl_nxt.emit_c0 = 1'b1;
        col_nxt         = COL_W'(1);
      end else if (col_zero) begin
        // single-row frame: load the first two columns at once
        ctl_nxt.dbl       = 1'b1;
        ctl_nxt.emit_main = 1'b1;
        ctl_nxt.right     = (width_r >= COL_W'(2));
        ctl_nxt.last      = (width_r == COL_W'(1));
        col_nxt           = COL_W'(2);
      end else begin
        ctl_nxt.emit_main = 1'b1;
        ctl_nxt.last      = (col_r == width_r);
        col_nxt           = col_r + COL_W'(1);
      end
      if (ctl_nxt.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= clamp_width(cfg_wdata[WIDTH_FW-1:0]);
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= clamp_height(cfg_wdata[ROW_W-1:0]);
          col_r    <= '0;
          row_r    <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line memory: read at acceptance, write back from stage one
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_a_r <= line_mem[addr_a];
      rd_b_r <= line_mem[addr_b];
    end
    if (s1_valid_r && s1_wr_r) begin
      line_mem[s1_addr_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_a_r    <= 1'b0;
      fwd_b_r    <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        fwd_a_r <= s1_valid_r && s1_wr_r && (s1_addr_r == addr_a);
        fwd_b_r <= s1_valid_r && s1_wr_r && (s1_addr_r == addr_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r   <= ctl_nxt;
      s1_wr_r    <= pix_go;
      s1_pix_r   <= in_pixel;
      s1_addr_r  <= addr_a;
      fwd_word_r <= wr_word;
    end
  end

  // stage one: shift the window and form the code
  always_comb begin
    line_a = fwd_a_r ? fwd_word_r : rd_a_r;
    line_b = fwd_b_r ? fwd_word_r : rd_b_r;

    col_a[0] = line_a.top;
    col_a[1] = line_a.mid;
    col_a[2] = s1_pix_r;
    col_b[0] = line_b.top;
    col_b[1] = line_b.mid;
    col_b[2] = s1_pix_r;

    if (s1_ctl_r.dbl) begin
      win_sh[0] = win_r[2];
      win_sh[1] = col_a;
      win_sh[2] = col_b;
    end else begin
      win_sh[0] = win_r[1];
      win_sh[1] = win_r[2];
      win_sh[2] = col_a;
    end

    win_c0[0] = win_r[1];
    win_c0[1] = win_r[2];
    win_c0[2] = '0;

    wr_word.top = line_a.mid;
    wr_word.mid = s1_pix_r;

    if (s1_ctl_r.emit_c0) begin
      res.code = lbp_calc(win_c0, s1_ctl_r.top0, 1'b1, s1_ctl_r.left0, 1'b0);
    end else begin
      res.code = lbp_calc(win_sh, s1_ctl_r.top, s1_ctl_r.bot, s1_ctl_r.left,
                          s1_ctl_r.right);
    end
    res.last = s1_ctl_r.last;
    s1_emit  = s1_valid_r && (s1_ctl_r.emit_c0 || s1_ctl_r.emit_main);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cfg_we && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT})) begin
      win_r <= '0;
    end else if (s1_valid_r && s1_ctl_r.shift) begin
      win_r <= s1_ctl_r.last ? '0 : win_sh;
    end
  end

  // output queue; hold the input while the queue might overflow
  assign pop            = out_valid && !out_stall;
  assign out_valid      = (cnt_r != '0);
  assign out_lbp_code   = fifo_mem[rd_ptr_r].code;
  assign out_frame_last = fifo_mem[rd_ptr_r].last;
  assign in_stall       = ((cnt_r + (FIFO_AW+1)'(s1_emit)) >= (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (s1_emit) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + (FIFO_AW+1)'(s1_emit) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

[tb/lbp_code_checker.sv]
// Checker for lbp_3x3_operator: tracks the pixel stream and both line stores,
// predicts each code and compares it with the result channel.
// Depends on lbp3_pkg.
module lbp_code_checker
  import lbp3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_kind,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [PIX_W-1:0]  out_lbp_code,
  input  logic              out_frame_last,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending_count
);

  // indexed [row][column], row 0 on top
  typedef pix_t [2:0][2:0] grid_t;

  typedef struct packed {
    pix_t code;
    logic last;
  } code_t;

  logic [WIDTH_FW-1:0] width_reg;
  logic [ROW_W-1:0]    height_reg;
  pix_t                above_row [MAX_WIDTH];
  pix_t                two_above_row [MAX_WIDTH];
  grid_t               win;
  int unsigned         col;
  int unsigned         row;
  int unsigned         emitted;
  code_t               expected_codes [$];
  int                  errors = 0;

  function automatic int unsigned cur_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned cur_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  function automatic pix_t lbp_of(input grid_t g, input bit has_top, input bit has_bot,
                                  input bit has_left, input bit has_right);
    pix_t c;
    pix_t v;
    c    = g[1][1];
    v    = '0;
    v[7] = has_top & has_left & (g[0][0] >= c);
    v[6] = has_top & (g[0][1] >= c);
    v[5] = has_top & has_right & (g[0][2] >= c);
    v[4] = has_right & (g[1][2] >= c);
    v[3] = has_bot & has_right & (g[2][2] >= c);
    v[2] = has_bot & (g[2][1] >= c);
    v[1] = has_bot & has_left & (g[2][0] >= c);
    v[0] = has_left & (g[1][0] >= c);
    return v;
  endfunction

  // code of the pixel centred in the window's right column, nothing to its right
  function automatic pix_t edge_code(input bit has_top, input bit has_left);
    grid_t g;
    g = '0;
    for (int r = 0; r < 3; r++) begin
      g[r][0] = win[r][1];
      g[r][1] = win[r][2];
    end
    return lbp_of(g, has_top, 1'b1, has_left, 1'b0);
  endfunction

  function automatic void clear_stream();
    win     = '0;
    col     = 0;
    row     = 0;
    emitted = 0;
  endfunction

  function automatic void push_code(input pix_t c, input logic l);
    expected_codes.push_back(code_t'{code: c, last: l});
  endfunction

  function automatic void predict_pixel(input pix_t p);
    int unsigned w;
    int unsigned h;
    pix_t        up2;
    pix_t        up1;
    bit          made;
    w    = cur_width();
    h    = cur_height();
    made = 1'b0;
    if (row >= h || col >= w) return;
    up2                = two_above_row[col];
    up1                = above_row[col];
    two_above_row[col] = up1;
    above_row[col]     = p;
    if (col == 0 && row >= 2) begin
      push_code(edge_code(row >= 3, w >= 2), 1'b0);
      made = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = p;
    if (col >= 1 && row >= 1) begin
      push_code(lbp_of(win, row >= 2, 1'b1, col >= 2, 1'b1), 1'b0);
      made = 1'b1;
    end
    if (made) emitted++;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
  endfunction

  function automatic void predict_flush();
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned left_over;
    int unsigned ec;
    grid_t       g;
    pix_t        c;
    w     = cur_width();
    h     = cur_height();
    total = w * h;
    if (row != h || emitted >= total) return;
    left_over = total - emitted;
    if (left_over == w + 1) begin
      c = edge_code(h >= 3, w >= 2);
    end else begin
      ec = w - left_over;
      g  = '0;
      if (ec < w) begin
        g[0][1] = two_above_row[ec];
        g[1][1] = above_row[ec];
        if (ec >= 1) begin
          g[0][0] = two_above_row[ec-1];
          g[1][0] = above_row[ec-1];
        end
        if (ec + 1 < w) begin
          g[0][2] = two_above_row[ec+1];
          g[1][2] = above_row[ec+1];
        end
      end
      c = lbp_of(g, h >= 2, 1'b0, ec >= 1, ec + 1 < w);
    end
    push_code(c, left_over == 1);
    emitted++;
    if (left_over == 1) clear_stream();
  endfunction

  always @(posedge clk) begin
    code_t want;
    if (!rst_n) begin
      width_reg  = WIDTH_FW'(WIDTH_RST);
      height_reg = HEIGHT_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        above_row[i]     = '0;
        two_above_row[i] = '0;
      end
      clear_stream();
      expected_codes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got code %02h frame_last %0b",
                   $time, out_lbp_code, out_frame_last);
        end else begin
          want = expected_codes.pop_front();
          if (out_lbp_code !== want.code) begin
            errors++;
            $display("%0t: lbp_code expected %02h, got %02h", $time, want.code, out_lbp_code);
          end
          if (out_frame_last !== want.last) begin
            errors++;
            $display("%0t: frame_last expected %0b, got %0b", $time, want.last,
                     out_frame_last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata[WIDTH_FW-1:0];
          clear_stream();
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_wdata;
          clear_stream();
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == KIND_FLUSH) predict_flush();
        else predict_pixel(in_pixel);
      end
    end
    fail_count    <= errors;
    pending_count <= expected_codes.size();
  end

endmodule

[tb/testbench.sv]
// Top of the lbp_3x3_operator testbench: clock, reset, frame stimulus and verdict.
// Depends on lbp3_pkg, lbp_3x3_operator and lbp_code_checker.
module testbench;
  import lbp3_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int IDLE_PCT      = 22;

  localparam logic [CFG_IW-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SPARE_HI = 2'd3;

  localparam int PIX_ANY  = 0;
  localparam int PIX_LOW  = 1;
  localparam int PIX_RAIL = 2;
  localparam int PIX_PAIR = 3;

  localparam int HOOK_NONE  = 0;
  localparam int HOOK_HOLD  = 1;
  localparam int HOOK_PAUSE = 2;
  localparam int HOOK_SPARE = 3;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic              in_kind        = KIND_PIXEL;
  logic [PIX_W-1:0]  in_pixel       = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic [PIX_W-1:0]  out_lbp_code;
  logic              out_frame_last;
  logic              cfg_we         = 1'b0;
  logic [CFG_IW-1:0] cfg_index      = REG_IMAGE_WIDTH;
  logic [CFG_DW-1:0] cfg_wdata      = '0;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int idle_pct    = IDLE_PCT;
  int stall_pct   = IDLE_PCT;
  int hold_asks   = 0;
  int hold_served = 0;
  int eff_w       = 128;
  int eff_h       = 128;
  int done_items  = 0;

  pix_t demo_img [0:8] = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd128, 8'd7, 8'd255, 8'd0, 8'd128};

  always #5 clk = ~clk;

  lbp_3x3_operator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lbp_code   (out_lbp_code),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  lbp_code_checker code_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_lbp_code   (out_lbp_code),
    .out_frame_last (out_frame_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_req(input kind_t k, input pix_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_pixel <= pix_t'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_pixel <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid, wait until every expected code is back, then hold a little longer
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_DW-1:0] wv, input logic [CFG_DW-1:0] hv);
    logic [WIDTH_FW-1:0] wf;
    wf = wv[WIDTH_FW-1:0];
    write_reg(REG_IMAGE_WIDTH, wv);
    write_reg(REG_IMAGE_HEIGHT, hv);
    eff_w = (wf == '0) ? 1 : (wf > MAX_WIDTH) ? MAX_WIDTH : int'(wf);
    eff_h = (hv == '0) ? 1 : int'(hv);
  endtask

  function automatic int flush_count();
    return (eff_h >= 2) ? eff_w + 1 : eff_w;
  endfunction

  function automatic pix_t pick_pixel(input int style);
    case (style)
      PIX_LOW:  return pix_t'($urandom_range(3));
      PIX_RAIL: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_PAIR: return pix_t'($urandom_range(101, 100));
      default:  return pix_t'($urandom);
    endcase
  endfunction

  task automatic run_frame(input int npix, input int style, input int hook);
    int total;
    total = eff_w * eff_h;
    for (int i = 0; i < npix; i++) begin
      if (i == npix / 2) begin
        case (hook)
          HOOK_HOLD:  hold_asks <= hold_asks + 1;
          HOOK_PAUSE: settle(0);
          HOOK_SPARE: begin
            settle(SETTLE_CYCLES);
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DW'($urandom));
          end
          default: ;
        endcase
      end
      if ($urandom_range(19) == 0) send_req(KIND_FLUSH, pix_t'($urandom));
      send_req(KIND_PIXEL, pick_pixel(style));
    end
    done_items += npix;
    if (npix == total) begin
      if ($urandom_range(3) == 0) send_req(KIND_PIXEL, pix_t'($urandom));
      repeat (flush_count()) send_req(KIND_FLUSH, pix_t'($urandom));
      done_items += flush_count();
      if ($urandom_range(4) == 0) send_req(KIND_FLUSH, pix_t'($urandom));
    end
  endtask

  initial begin : stimulus
    int                w;
    int                h;
    int                total;
    int                npix;
    int                hook;
    int                phase;
    logic [CFG_DW-1:0] wv;
    logic [CFG_DW-1:0] hv;
    bit                hold_done;
    bit                pause_done;
    bit                big_done;
    bit                abort;
    phase      = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    big_done   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: flush mid-frame, pixel after the frame, flush with nothing pending
    set_dims(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_req(KIND_FLUSH, 8'hA5);
      send_req(KIND_PIXEL, demo_img[i]);
    end
    send_req(KIND_PIXEL, 8'h11);
    repeat (flush_count()) send_req(KIND_FLUSH, 8'h00);
    send_req(KIND_FLUSH, 8'hFF);
    settle(SETTLE_CYCLES);

    // zero width and height act as one
    set_dims(16'd0, 16'd0);
    send_req(KIND_PIXEL, 8'hFF);
    send_req(KIND_FLUSH, 8'h00);
    settle(SETTLE_CYCLES);
    write_reg(REG_SPARE_HI, 16'hFFFF);

    set_dims(16'd1, 16'd3);
    send_req(KIND_PIXEL, 8'h00);
    send_req(KIND_PIXEL, 8'hFF);
    send_req(KIND_PIXEL, 8'h00);
    repeat (flush_count()) send_req(KIND_FLUSH, 8'h00);
    settle(SETTLE_CYCLES);

    while (done_items < RANDOM_ITEMS) begin
      phase++;
      if (phase == 3 || $urandom_range(7) == 0) begin
        idle_pct  <= 0;
        stall_pct <= 0;
      end else begin
        idle_pct  <= IDLE_PCT;
        stall_pct <= IDLE_PCT;
      end

      if (!big_done && done_items > 250) begin
        big_done = 1'b1;
        set_dims(16'd2047, 16'd2);
        run_frame(MAX_WIDTH + 8, PIX_ANY, HOOK_NONE);
        settle(SETTLE_CYCLES);
        set_dims(16'd1024, 16'd1);
        run_frame(12, PIX_RAIL, HOOK_NONE);
        settle(SETTLE_CYCLES);
        set_dims(16'd1, 16'hFFFF);
        run_frame(24, PIX_LOW, HOOK_NONE);
        settle(SETTLE_CYCLES);
      end

      if (!hold_done && done_items > 100) begin
        w = 10;
        h = 8;
      end else begin
        w = ($urandom_range(9) == 0) ? $urandom_range(32, 11) : $urandom_range(10, 1);
        h = $urandom_range(6, 1);
      end
      wv = (w == 1 && $urandom_range(1)) ? '0 : CFG_DW'(w);
      hv = (h == 1 && $urandom_range(1)) ? '0 : CFG_DW'(h);
      set_dims(wv, hv);

      repeat ($urandom_range(3, 1)) begin
        total = eff_w * eff_h;
        abort = (total > 1) && ($urandom_range(9) == 0);
        npix  = abort ? $urandom_range(total - 1, 1) : total;
        hook  = HOOK_NONE;
        if (!hold_done && done_items > 100 && npix >= 40) begin
          hook      = HOOK_HOLD;
          hold_done = 1'b1;
        end else if (!pause_done && done_items > 160 && npix >= 8) begin
          hook       = HOOK_PAUSE;
          pause_done = 1'b1;
        end else if ($urandom_range(15) == 0) begin
          hook = HOOK_SPARE;
        end
        run_frame(npix, $urandom_range(PIX_PAIR, PIX_ANY), hook);
        if (abort) break;
      end
      settle(SETTLE_CYCLES);
    end

    settle(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
